>>> design/layer_bucket_linker_defines.svh
// assertion macros used by the datapath
// clocked on aclk, held off while aresetn is low
`ifndef LAYER_BUCKET_LINKER_DEFINES_SVH
`define LAYER_BUCKET_LINKER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LBL_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("layer bucket linker check failed");

// next-cycle implication
`define LBL_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("layer bucket linker check failed");

`else

`define LBL_ASSERT_IMP(label, pre, post)
`define LBL_ASSERT_NXT(label, pre, post)

`endif

`endif

>>> design/lbl_pkg.sv
`default_nettype none

package lbl_pkg;

    localparam int SIZE_W      = 7;
    localparam int IDX_W       = 6;
    localparam int WEIGHT_W    = 32;
    localparam int BUCKET_W    = 24;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;

    localparam logic [BUCKET_W-1:0] BUCKET_MAX = 24'hFFFFFF;

    typedef logic [1:0] action_t;

    localparam action_t ACT_START = 2'd0;
    localparam action_t ACT_LINK  = 2'd1;
    localparam action_t ACT_CLOSE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LINK_WR,
        ST_START_EMIT,
        ST_CLOSE_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic link_write;
        logic emit_start;
        logic emit_close;
    } lbl_cmd_t;

    typedef struct packed {
        action_t action;
        logic    size_zero;
        logic    out_free;
        logic    emit_last;
    } lbl_status_t;

endpackage

`default_nettype wire

>>> design/lbl_ctrl.sv
`default_nettype none

module lbl_ctrl
    import lbl_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire lbl_status_t status,
    output lbl_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    priority case (status.action)
                        ACT_LINK:  state_next = ST_LINK_WR;
                        ACT_START: state_next = status.size_zero ? ST_IDLE : ST_START_EMIT;
                        ACT_CLOSE: state_next = status.size_zero ? ST_IDLE : ST_CLOSE_EMIT;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LINK_WR: begin
                cmd.link_write = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_START_EMIT: begin
                cmd.emit_start = status.out_free;
                if (status.out_free && status.emit_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLOSE_EMIT: begin
                cmd.emit_close = status.out_free;
                if (status.out_free && status.emit_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

>>> design/lbl_datapath.sv
`default_nettype none

`include "layer_bucket_linker_defines.svh"

module lbl_datapath
    import lbl_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire action_t                s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    output logic                        m_tlast,
    input  wire lbl_cmd_t               cmd,
    output lbl_status_t                 status
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

    // input fields
    logic [SIZE_W-1:0]   layer_size;
    logic [IDX_W-1:0]    src_index;
    logic [IDX_W-1:0]    target_index;
    logic [WEIGHT_W-1:0] weight;
    logic [SIZE_W-1:0]   n_in;

    assign layer_size   = s_tdata[6:0];
    assign src_index    = s_tdata[12:7];
    assign target_index = s_tdata[18:13];
    assign weight       = s_tdata[50:19];

    assign n_in = (layer_size > SIZE_W'(MAX_ITEMS)) ? SIZE_W'(MAX_ITEMS) : layer_size;

    // state
    logic [BUCKET_W-1:0]  cb_mem [MAX_ITEMS];
    logic [BUCKET_W-1:0]  lb_mem [MAX_ITEMS];
    logic [WEIGHT_W-1:0]  lw_mem [MAX_ITEMS];
    logic [BUCKET_W-1:0]  cb_rd_reg;
    logic [BUCKET_W-1:0]  lb_rd_reg;
    logic [WEIGHT_W-1:0]  lw_rd_reg;
    logic [MAX_ITEMS-1:0] link_valid_reg;
    logic [MAX_ITEMS-1:0] link_valid_next;
    logic [BUCKET_W-1:0]  fresh_reg;
    logic [BUCKET_W-1:0]  fresh_next;
    logic                 ovf_reg;
    logic                 ovf_next;
    logic [SIZE_W-1:0]    cur_size_reg;
    logic [AW-1:0]        idx_reg;
    logic [AW-1:0]        tgt_reg;
    logic [WEIGHT_W-1:0]  w_reg;
    logic                 link_ok_reg;

    // output register
    logic                 m_tvalid_reg;
    logic [IDX_W-1:0]     pos_reg;
    logic [BUCKET_W-1:0]  bucket_reg;
    logic [BUCKET_W-1:0]  total_reg;
    logic                 out_ovf_reg;
    logic                 last_reg;

    logic                 emit;
    logic                 emit_last;
    logic                 out_free;
    logic                 link_take;
    logic                 size_accept;
    logic [BUCKET_W-1:0]  bucket_sel;
    logic [AW-1:0]        lb_raddr;
    logic [AW-1:0]        idx_inc;

    assign emit      = cmd.emit_start | cmd.emit_close;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit_last = (SIZE_W'(idx_reg) + SIZE_W'(1)) == cur_size_reg;
    assign idx_inc   = AW'(idx_reg + AW'(1));

    assign size_accept = cmd.accept && (s_tuser == ACT_START || s_tuser == ACT_CLOSE);

    assign status.action    = s_tuser;
    assign status.size_zero = (n_in == '0);
    assign status.out_free  = out_free;
    assign status.emit_last = emit_last;

    // link table entry replaced only by a strictly heavier offer
    assign link_take = cmd.link_write && link_ok_reg &&
                       (!link_valid_reg[tgt_reg] || $signed(lw_rd_reg) < $signed(w_reg));

    assign lb_raddr = (cmd.emit_close) ? idx_inc : idx_reg;

    always_comb begin
        bucket_sel = BUCKET_W'(idx_reg);
        fresh_next = fresh_reg;
        ovf_next   = ovf_reg;
        if (cmd.accept && s_tuser == ACT_START) begin
            fresh_next = '0;
            ovf_next   = 1'b0;
        end else if (cmd.emit_start) begin
            bucket_sel = BUCKET_W'(idx_reg);
            fresh_next = BUCKET_W'(idx_reg) + BUCKET_W'(1);
            ovf_next   = 1'b0;
        end else if (cmd.emit_close) begin
            if (link_valid_reg[idx_reg]) begin
                bucket_sel = lb_rd_reg;
            end else if (fresh_reg == BUCKET_MAX) begin
                bucket_sel = BUCKET_MAX;
                ovf_next   = 1'b1;
            end else begin
                bucket_sel = fresh_reg;
                fresh_next = fresh_reg + BUCKET_W'(1);
            end
        end
    end

    always_comb begin
        link_valid_next = link_valid_reg;
        if ((cmd.accept && s_tuser == ACT_START) ||
            (cmd.accept && s_tuser == ACT_CLOSE && n_in == '0) ||
            (cmd.emit_close && emit_last)) begin
            link_valid_next = '0;
        end else if (link_take) begin
            link_valid_next[tgt_reg] = 1'b1;
        end
    end

    // memories
    always_ff @(posedge aclk) begin
        if (emit) begin
            cb_mem[idx_reg] <= bucket_sel;
        end
        cb_rd_reg <= cb_mem[src_index[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (link_take) begin
            lb_mem[tgt_reg] <= cb_rd_reg;
        end
        lb_rd_reg <= lb_mem[lb_raddr];
    end

    always_ff @(posedge aclk) begin
        if (link_take) begin
            lw_mem[tgt_reg] <= w_reg;
        end
        lw_rd_reg <= lw_mem[target_index[AW-1:0]];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_valid_reg <= '0;
            fresh_reg      <= '0;
            ovf_reg        <= 1'b0;
            cur_size_reg   <= '0;
            idx_reg        <= '0;
            link_ok_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            link_valid_reg <= link_valid_next;
            fresh_reg      <= fresh_next;
            ovf_reg        <= ovf_next;
            if (size_accept) begin
                cur_size_reg <= n_in;
            end
            if (cmd.accept) begin
                idx_reg     <= '0;
                link_ok_reg <= (s_tuser == ACT_LINK) &&
                               (SIZE_W'(src_index) < cur_size_reg) &&
                               (SIZE_W'(target_index) < SIZE_W'(MAX_ITEMS));
            end else if (emit) begin
                idx_reg <= idx_inc;
            end
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            tgt_reg <= target_index[AW-1:0];
            w_reg   <= weight;
        end
        if (emit) begin
            pos_reg     <= IDX_W'(idx_reg);
            bucket_reg  <= bucket_sel;
            total_reg   <= fresh_next;
            out_ovf_reg <= ovf_next;
            last_reg    <= emit_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {1'b0, out_ovf_reg, total_reg, bucket_reg, pos_reg};

    `LBL_ASSERT_IMP(a_emit_has_room, emit, out_free)
    `LBL_ASSERT_IMP(a_emit_in_layer, emit, SIZE_W'(idx_reg) < cur_size_reg)
    `LBL_ASSERT_IMP(a_ovf_saturated, ovf_reg, fresh_reg == BUCKET_MAX)
    `LBL_ASSERT_NXT(a_links_cleared, cmd.emit_close && emit_last, link_valid_reg == '0)
    `LBL_ASSERT_NXT(a_fresh_monotonic, !(cmd.accept && s_tuser == ACT_START) && !cmd.emit_start,
        fresh_reg >= $past(fresh_reg))

endmodule

`default_nettype wire

>>> design/layer_bucket_linker.sv
// link offer: accept, then one read-compare-write of the link table before the next beat
// start or close of n items: results leave the output register one a cycle while m_tready
//   is high; n = 0 gives no results
// close reads link buckets through a registered read port, addressed one item ahead
// reset: synchronous, active low; clears the fsm, link valid bits, fresh counter,
//   layer size, overflow flag and output valid; bucket memories are not cleared
`default_nettype none

module layer_bucket_linker
    import lbl_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // input beats
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // layer_size[6:0], src_index[12:7], target_index[18:13], weight[50:19], zero fill
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // action[1:0]
    input  wire logic [1:0]             s_tuser,
    // result beats
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // position[5:0], bucket[29:6], bucket_total[53:30], overflow[54], zero fill
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    // last position of the emitted layer
    output logic                        m_tlast
);

    // command and status between the sequencer and the datapath
    lbl_cmd_t    cmd;
    lbl_status_t status;

    // sequencer: idle, link update, start walk, close walk
    lbl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: bucket and link memories, fresh counter, output register
    lbl_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (action_t'(s_tuser)),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

`default_nettype wire

>>> tb/layer_bucket_linker_tb.sv
`timescale 1ns / 100ps

module layer_bucket_linker_tb;
    import lbl_pkg::*;

    localparam int LAYER_MAX   = 64;
    localparam int RAND_ITEMS  = 190;
    localparam int CALM_ITEMS  = 40;    // closing stretch with no idling
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int DRAIN_WAIT  = 80;    // a full layer plus margin
    localparam int MAX_PRINTS  = 60;

    // action 3 carries no meaning and is dropped by the block
    localparam action_t ACT_NONE = 2'd3;

    typedef struct {
        action_t     act;
        logic [6:0]  size;
        logic [5:0]  item;
        logic [5:0]  target;
        logic [31:0] weight;
        bit          typed;     // expected beats written in the row
        int          n_typed;
        int          base;
    } stim_row_t;

    typedef struct {
        logic [5:0]  pos;
        logic [23:0] bucket;
        logic [23:0] total;
        logic        ovf;
        logic        last;
    } bucket_beat_t;

    localparam int N_ROWS = 25;

    // directed rows; typed rows give n beats with bucket base+i and total base+i+1
    stim_row_t dir_rows [0:N_ROWS-1] = '{
        '{ACT_CLOSE, 7'd4,   6'd0,  6'd0,  32'h0000_0000, 1'b1, 4,  0}, // close before start
        '{ACT_START, 7'd64,  6'd0,  6'd0,  32'h0000_0000, 1'b1, 64, 0}, // largest layer
        '{ACT_START, 7'd127, 6'd0,  6'd0,  32'h0000_0000, 1'b1, 64, 0}, // oversized layer
        '{ACT_START, 7'd0,   6'd0,  6'd0,  32'h0000_0000, 1'b1, 0,  0}, // empty layer
        '{ACT_CLOSE, 7'd3,   6'd0,  6'd0,  32'h0000_0000, 1'b1, 3,  0}, // from empty layer
        '{ACT_START, 7'd5,   6'd0,  6'd0,  32'h0000_0000, 1'b1, 5,  0},
        '{ACT_LINK,  7'd0,   6'd0,  6'd0,  32'h7FFF_FFFF, 1'b1, 0,  0}, // top weight
        '{ACT_LINK,  7'd0,   6'd1,  6'd0,  32'h7FFF_FFFF, 1'b1, 0,  0}, // tie, first stays
        '{ACT_LINK,  7'd0,   6'd2,  6'd1,  32'h8000_0000, 1'b1, 0,  0}, // bottom weight
        '{ACT_LINK,  7'd0,   6'd3,  6'd1,  32'h8000_0001, 1'b1, 0,  0}, // just above, replaces
        '{ACT_LINK,  7'd0,   6'd4,  6'd63, 32'h0000_0000, 1'b1, 0,  0}, // top target
        '{ACT_LINK,  7'd0,   6'd5,  6'd2,  32'h0000_0000, 1'b1, 0,  0}, // stale item
        '{ACT_LINK,  7'd0,   6'd63, 6'd3,  32'h7FFF_FFFF, 1'b1, 0,  0}, // stale item
        '{ACT_LINK,  7'd0,   6'd1,  6'd2,  32'hFFFF_FFFF, 1'b1, 0,  0},
        '{ACT_LINK,  7'd0,   6'd4,  6'd2,  32'hFFFF_FFFF, 1'b1, 0,  0}, // tie on minus one
        '{ACT_NONE,  7'd127, 6'd63, 6'd63, 32'hFFFF_FFFF, 1'b1, 0,  0}, // unknown action
        '{ACT_CLOSE, 7'd127, 6'd0,  6'd0,  32'h0000_0000, 1'b0, 0,  0}, // oversized close
        '{ACT_LINK,  7'd0,   6'd63, 6'd5,  32'h1234_5678, 1'b1, 0,  0},
        '{ACT_LINK,  7'd0,   6'd0,  6'd40, 32'h0000_0001, 1'b1, 0,  0}, // dropped at close
        '{ACT_CLOSE, 7'd10,  6'd0,  6'd0,  32'h0000_0000, 1'b0, 0,  0},
        '{ACT_LINK,  7'd0,   6'd2,  6'd0,  32'h0000_0005, 1'b1, 0,  0}, // cleared by restart
        '{ACT_START, 7'd1,   6'd0,  6'd0,  32'h0000_0000, 1'b1, 1,  0}, // restart
        '{ACT_CLOSE, 7'd2,   6'd0,  6'd0,  32'h0000_0000, 1'b0, 0,  0},
        '{ACT_CLOSE, 7'd0,   6'd0,  6'd0,  32'h0000_0000, 1'b1, 0,  0}, // empty close
        '{ACT_CLOSE, 7'd64,  6'd0,  6'd0,  32'h0000_0000, 1'b0, 0,  0}  // fresh from empty
    };

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [1:0]             s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    // predictor copy of the block state
    logic [23:0]        layer_buckets [LAYER_MAX];
    bit                 link_set      [LAYER_MAX];
    logic [23:0]        link_src      [LAYER_MAX];
    logic signed [31:0] link_w        [LAYER_MAX];
    logic [23:0]        fresh_cnt;
    int                 layer_len;
    bit                 ovf_sticky;

    bucket_beat_t bucket_q [$];

    int n_errors  = 0;
    int n_sent    = 0;
    bit idle_on   = 1'b1;
    bit hold_ask  = 1'b0;

    layer_bucket_linker #(
        .MAX_ITEMS (LAYER_MAX)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        if (n_errors < MAX_PRINTS) begin
            $display("mismatch on %s: got %0h, expected %0h", field, got, want);
        end
        n_errors++;
    endtask

    // work out the bucket beats that one accepted input beat causes
    task automatic predict_beats(action_t act, logic [6:0] size_f, logic [5:0] item,
                                 logic [5:0] target, logic signed [31:0] w, bit keep);
        int           n;
        bucket_beat_t b;
        logic [23:0]  id;
        n = (size_f > LAYER_MAX) ? LAYER_MAX : int'(size_f);
        case (act)
            ACT_START: begin
                foreach (link_set[i]) link_set[i] = 1'b0;
                ovf_sticky = 1'b0;
                fresh_cnt  = '0;
                for (int i = 0; i < n; i++) begin
                    layer_buckets[i] = 24'(i);
                    fresh_cnt        = 24'(i + 1);
                    b = '{6'(i), 24'(i), fresh_cnt, 1'b0, i == n - 1};
                    if (keep) bucket_q = {bucket_q, b};
                end
                layer_len = n;
            end
            ACT_LINK: begin
                // a stale item is dropped; every 6-bit target is in range
                if (int'(item) < layer_len) begin
                    if (!link_set[target] || link_w[target] < w) begin
                        link_set[target] = 1'b1;
                        link_src[target] = layer_buckets[item];
                        link_w[target]   = w;
                    end
                end
            end
            ACT_CLOSE: begin
                for (int i = 0; i < n; i++) begin
                    if (link_set[i]) begin
                        id = link_src[i];
                    end else if (fresh_cnt >= BUCKET_MAX) begin
                        // saturation, far out of reach in a run of this length
                        id         = BUCKET_MAX;
                        ovf_sticky = 1'b1;
                    end else begin
                        id        = fresh_cnt;
                        fresh_cnt = fresh_cnt + 24'd1;
                    end
                    layer_buckets[i] = id;
                    b = '{6'(i), id, fresh_cnt, ovf_sticky, i == n - 1};
                    if (keep) bucket_q = {bucket_q, b};
                end
                foreach (link_set[i]) link_set[i] = 1'b0;
                layer_len = n;
            end
            default: begin
            end
        endcase
    endtask

    // offer one input beat and hold it until the block takes it
    task automatic send_beat(action_t act, logic [6:0] size_f, logic [5:0] item,
                             logic [5:0] target, logic [31:0] w, bit keep);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {5'b0, w, target, item, size_f};
        do @(posedge aclk); while (!s_tready);
        predict_beats(act, size_f, item, target, w, keep);
        n_sent++;
    endtask

    function automatic logic [6:0] pick_size();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 7'd64;
        if (r == 1) return 7'($urandom_range(65, 127));
        if (r == 2) return 7'd0;
        return 7'($urandom_range(1, 12));
    endfunction

    function automatic logic [31:0] pick_weight();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            4: return 32'h0001_0000;   // 1.0, often repeated for ties
            default: return $urandom;
        endcase
    endfunction

    // stimulus
    initial begin
        stim_row_t    row;
        bucket_beat_t b;
        logic [6:0]   nsz;
        int           n_links;
        int           tgt_hi;
        int           rand_end;
        bit           paused;

        foreach (link_set[i]) link_set[i] = 1'b0;
        fresh_cnt  = '0;
        layer_len  = 0;
        ovf_sticky = 1'b0;
        paused     = 1'b0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int r = 0; r < N_ROWS; r++) begin
            row = dir_rows[r];
            if (row.typed) begin
                for (int i = 0; i < row.n_typed; i++) begin
                    b = '{6'(i), 24'(row.base + i), 24'(row.base + i + 1), 1'b0,
                          i == row.n_typed - 1};
                    bucket_q = {bucket_q, b};
                end
            end
            send_beat(row.act, row.size, row.item, row.target, row.weight, !row.typed);
        end

        // receiver holds off while a full layer and what follows pile up
        hold_ask = 1'b1;
        send_beat(ACT_START, 7'd64, 6'($urandom), 6'($urandom), $urandom, 1'b1);

        rand_end = n_sent + RAND_ITEMS;
        while (n_sent < rand_end) begin
            if (n_sent >= rand_end - CALM_ITEMS) idle_on = 1'b0;

            // once, mid-run, let the block drain completely
            if (!paused && n_sent >= rand_end - RAND_ITEMS / 2) begin
                paused = 1'b1;
                s_tvalid <= 1'b0;
                while (bucket_q.size() != 0) @(posedge aclk);
                repeat (4) @(posedge aclk);
            end

            if ($urandom_range(0, 9) < 8) begin
                // well-formed layer: optional start, links, close
                if (layer_len == 0 || $urandom_range(0, 3) == 0) begin
                    send_beat(ACT_START, pick_size(), 6'($urandom), 6'($urandom),
                              $urandom, 1'b1);
                end
                nsz     = pick_size();
                tgt_hi  = (nsz == 0) ? 0 : ((nsz > LAYER_MAX) ? LAYER_MAX - 1 : nsz - 1);
                n_links = $urandom_range(0, 12);
                for (int k = 0; k < n_links; k++) begin
                    if (layer_len > 0 && $urandom_range(0, 9) != 0) begin
                        send_beat(ACT_LINK, 7'($urandom),
                                  6'($urandom_range(0, layer_len - 1)),
                                  ($urandom_range(0, 7) == 0) ? 6'($urandom)
                                                              : 6'($urandom_range(0, tgt_hi)),
                                  pick_weight(), 1'b1);
                    end else begin
                        // stale item or arbitrary link
                        send_beat(ACT_LINK, 7'($urandom), 6'($urandom), 6'($urandom),
                                  $urandom, 1'b1);
                    end
                end
                send_beat(ACT_CLOSE, nsz, 6'($urandom), 6'($urandom), $urandom, 1'b1);
            end else begin
                // noise beat with every field random
                send_beat(action_t'($urandom_range(0, 3)),
                          ($urandom_range(0, 3) == 0) ? 7'($urandom) : pick_size(),
                          6'($urandom), 6'($urandom), $urandom, 1'b1);
            end
        end

        s_tvalid <= 1'b0;
        while (bucket_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_ask) begin
                m_tready <= 1'b0;
                hold_ask = 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // result checker: each beat against the oldest expectation
    initial begin
        bucket_beat_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (bucket_q.size() == 0) begin
                    report_mismatch("unexpected beat", m_tdata[31:0], '0);
                end else begin
                    want = bucket_q.pop_front();
                    if (m_tdata[5:0] !== want.pos)
                        report_mismatch("position", 32'(m_tdata[5:0]), 32'(want.pos));
                    if (m_tdata[29:6] !== want.bucket)
                        report_mismatch("bucket", 32'(m_tdata[29:6]), 32'(want.bucket));
                    if (m_tdata[53:30] !== want.total)
                        report_mismatch("bucket_total", 32'(m_tdata[53:30]),
                                        32'(want.total));
                    if (m_tdata[54] !== want.ovf)
                        report_mismatch("overflow", 32'(m_tdata[54]), 32'(want.ovf));
                    if (m_tlast !== want.last)
                        report_mismatch("last", 32'(m_tlast), 32'(want.last));
                end
            end
        end
    end

    // overall time limit
    initial begin
        #(5_000_000);
        $display("FAIL");
        $finish;
    end

endmodule
